[src/grid_dda_column_raycaster_core_assert.svh]
// assertion macros for the raycaster core
`ifndef GRID_DDA_COLUMN_RAYCASTER_CORE_ASSERT_SVH
`define GRID_DDA_COLUMN_RAYCASTER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define GDCR_ASSERT_SAME(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define GDCR_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[src/gdcr_pkg.sv]
// shared types, constants and helpers of the raycaster core
package gdcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAP_SIDE  = 64;
    localparam int MAP_AW    = 12;
    localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;

    localparam logic [23:0] PERP_MAX  = 24'hFFFFFF;
    localparam logic [38:0] DELTA_CAP = 39'h40_0000_0000;

    // item operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // register indexes
    localparam logic [2:0] REG_SCREEN_W = 3'd0;
    localparam logic [2:0] REG_SCREEN_H = 3'd1;
    localparam logic [2:0] REG_POS_X    = 3'd2;
    localparam logic [2:0] REG_POS_Y    = 3'd3;
    localparam logic [2:0] REG_DIR_X    = 3'd4;
    localparam logic [2:0] REG_DIR_Y    = 3'd5;
    localparam logic [2:0] REG_PLANE_X  = 3'd6;
    localparam logic [2:0] REG_PLANE_Y  = 3'd7;

    // datapath command codes
    localparam logic [4:0] DP_NONE     = 5'd0;
    localparam logic [4:0] DP_LOAD     = 5'd1;
    localparam logic [4:0] DP_MEMWR    = 5'd2;
    localparam logic [4:0] DP_CLR      = 5'd3;
    localparam logic [4:0] DP_DIV_CAM  = 5'd4;
    localparam logic [4:0] DP_CAP_CAM  = 5'd5;
    localparam logic [4:0] DP_PROD     = 5'd6;
    localparam logic [4:0] DP_RAY      = 5'd7;
    localparam logic [4:0] DP_MUL_SQX  = 5'd8;
    localparam logic [4:0] DP_CAP_SQX  = 5'd9;
    localparam logic [4:0] DP_MUL_SQY  = 5'd10;
    localparam logic [4:0] DP_CAP_SQY  = 5'd11;
    localparam logic [4:0] DP_SQRT     = 5'd12;
    localparam logic [4:0] DP_CAP_LEN  = 5'd13;
    localparam logic [4:0] DP_DIV_DDX  = 5'd14;
    localparam logic [4:0] DP_CAP_DDX  = 5'd15;
    localparam logic [4:0] DP_DIV_DDY  = 5'd16;
    localparam logic [4:0] DP_CAP_DDY  = 5'd17;
    localparam logic [4:0] DP_MUL_SDX  = 5'd18;
    localparam logic [4:0] DP_CAP_SDX  = 5'd19;
    localparam logic [4:0] DP_MUL_SDY  = 5'd20;
    localparam logic [4:0] DP_CAP_SDY  = 5'd21;
    localparam logic [4:0] DP_STEP     = 5'd22;
    localparam logic [4:0] DP_LOST     = 5'd23;
    localparam logic [4:0] DP_HIT      = 5'd24;
    localparam logic [4:0] DP_DIV_DIST = 5'd25;
    localparam logic [4:0] DP_CAP_DIST = 5'd26;
    localparam logic [4:0] DP_DIV_ROW  = 5'd27;
    localparam logic [4:0] DP_CAP_ROW  = 5'd28;
    localparam logic [4:0] DP_FIN      = 5'd29;

    typedef struct packed {
        logic       operation;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [7:0] map_char;
        logic [11:0] column_x;
    } item_t;

    typedef struct packed {
        logic        hit_side;
        logic [1:0]  wall_face;
        logic [5:0]  hit_cell_x;
        logic [5:0]  hit_cell_y;
        logic [23:0] perp_distance;
        logic [11:0] wall_top_row;
        logic [11:0] wall_bottom_row;
        logic        left_map;
    } result_t;

    typedef struct packed {
        logic [11:0]        screen_width;
        logic [11:0]        screen_height;
        logic [21:0]        player_pos_x;
        logic [21:0]        player_pos_y;
        logic signed [17:0] view_dir_x;
        logic signed [17:0] view_dir_y;
        logic signed [17:0] cam_plane_x;
        logic signed [17:0] cam_plane_y;
    } cfg_t;

    typedef struct packed {
        logic [4:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic mul_done;
        logic sqrt_done;
        logic out_of_map;
        logic wall;
        logic steps_done;
        logic den_zero;
    } dp_status_t;

    // walkable characters: NUL and the open set
    function automatic logic is_open(input logic [7:0] c);
        return c inside {8'h00, "0", "2", "3", "E", "N", "S", "W", "B", "A", "O",
                         "T", "F", "Q"};
    endfunction

    // floor(h / 50) for 12 bit h by reciprocal multiply
    function automatic logic [6:0] div_by_50(input logic [11:0] h);
        logic [22:0] p;
        p = {11'b0, h} * 23'd1311;
        return p[22:16];
    endfunction

endpackage

[src/gdcr_div.sv]
// restoring divider, one quotient bit per cycle
module gdcr_div
    import gdcr_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[src/gdcr_isqrt.sv]
// integer square root, one result bit per cycle
module gdcr_isqrt
    import gdcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] n_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic [63:0] rb;

    assign rb = r_reg + b_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // digit by digit root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= rad;
            r_reg <= '0;
            b_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (n_reg >= rb)
            begin
                n_reg <= n_reg - rb;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

[src/gdcr_dp.sv]
// raycaster datapath: map memory, ray setup, dda walk and projection
module gdcr_dp
    import gdcr_pkg::*;
#(
    parameter int MAX_STEPS = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  item_t      item,
    input  cfg_t       cfg,
    output dp_status_t status,
    output result_t    result
);

    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    item_t              item_reg;
    logic               wall_map_reg [MAP_CELLS];
    logic               rdata_reg;
    logic [MAP_AW-1:0]  clr_cnt_reg;
    logic signed [30:0] cam_reg;
    logic signed [48:0] px_reg;
    logic signed [48:0] py_reg;
    logic signed [32:0] rx_reg;
    logic signed [32:0] ry_reg;
    logic [31:0]        ax_reg;
    logic [31:0]        ay_reg;
    logic [63:0]        sq_reg;
    logic [31:0]        len_reg;
    logic [38:0]        ddx_reg;
    logic [38:0]        ddy_reg;
    logic [47:0]        sdx_reg;
    logic [47:0]        sdy_reg;
    logic signed [7:0]  mx_reg;
    logic signed [7:0]  my_reg;
    logic               side_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [23:0]        an_reg;
    logic [31:0]        den_reg;
    logic signed [49:0] rh_reg;
    result_t            res_reg;

    // serial multiplier
    logic        mul_busy_reg;
    logic        mul_done_reg;
    logic [4:0]  mul_cnt_reg;
    logic [63:0] mul_a_reg;
    logic [31:0] mul_b_reg;
    logic [63:0] mul_acc_reg;
    logic        mul_start;
    logic [63:0] mul_a;
    logic [31:0] mul_b;

    logic        div_start;
    logic [47:0] div_num;
    logic [31:0] div_den;
    logic        div_done;
    logic [47:0] div_quo;
    logic        sqrt_done;
    logic [31:0] sqrt_root;

    logic [11:0]        h_eff;
    logic [11:0]        w_eff;
    logic [6:0]         hq;
    logic [23:0]        d_eff;
    logic signed [32:0] rx_c;
    logic signed [32:0] ry_c;
    logic               rx_pos;
    logic               ry_pos;
    logic [16:0]        fx_term;
    logic [16:0]        fy_term;
    logic signed [24:0] num_c;
    logic signed [50:0] hb;
    logic signed [50:0] t2;
    logic signed [50:0] b2;
    logic [32:0]        bs;
    logic               mem_we;
    logic [MAP_AW-1:0]  mem_waddr;
    logic               mem_wdata;

    assign h_eff  = (cfg.screen_height == 12'd0) ? 12'd1 : cfg.screen_height;
    assign w_eff  = (cfg.screen_width == 12'd0) ? 12'd1 : cfg.screen_width;
    assign hq     = div_by_50(h_eff);
    assign d_eff  = (res_reg.perp_distance == 24'd0) ? 24'd1 : res_reg.perp_distance;
    assign rx_pos = !rx_reg[32] && (rx_reg != 33'sd0);
    assign ry_pos = !ry_reg[32] && (ry_reg != 33'sd0);

    // first partial step, pos fraction or its complement
    assign fx_term = rx_pos ? {1'b0, cfg.player_pos_x[15:0]}
                            : 17'h10000 - {1'b0, cfg.player_pos_x[15:0]};
    assign fy_term = ry_pos ? {1'b0, cfg.player_pos_y[15:0]}
                            : 17'h10000 - {1'b0, cfg.player_pos_y[15:0]};

    // ray components from registered camera products
    assign rx_c = $signed(px_reg[48:16]) - 33'(cfg.view_dir_x);
    assign ry_c = $signed(py_reg[48:16]) - 33'(cfg.view_dir_y);

    // distance numerator on the hit axis
    always_comb
    begin
        if (!side_reg)
            num_c = $signed({3'b0, mx_reg[5:0], 16'b0}) - $signed({3'b0, cfg.player_pos_x})
                  + (rx_pos ? 25'sd65536 : 25'sd0);
        else
            num_c = $signed({3'b0, my_reg[5:0], 16'b0}) - $signed({3'b0, cfg.player_pos_y})
                  + (ry_pos ? 25'sd65536 : 25'sd0);
    end

    // slice rows from the projected height
    assign hb = $signed({23'b0, h_eff[11:1], 17'b0});
    assign t2 = hb - 51'(rh_reg);
    assign b2 = hb + 51'(rh_reg);
    assign bs = b2[49:17];

    // divider operand select
    always_comb
    begin
        div_start = 1'b1;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            DP_DIV_CAM:
            begin
                div_num = {19'b0, item_reg.column_x, 17'b0};
                div_den = {20'b0, w_eff};
            end
            DP_DIV_DDX:
            begin
                div_num = {len_reg, 16'b0};
                div_den = ax_reg;
            end
            DP_DIV_DDY:
            begin
                div_num = {len_reg, 16'b0};
                div_den = ay_reg;
            end
            DP_DIV_DIST:
            begin
                div_num = {8'b0, an_reg, 16'b0};
                div_den = den_reg;
            end
            DP_DIV_ROW:
            begin
                div_num = {4'b0, h_eff, 32'b0};
                div_den = {8'b0, d_eff};
            end
            default: div_start = 1'b0;
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        mul_start = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        case (cmd.op)
            DP_MUL_SQX:
            begin
                mul_a = {32'b0, ax_reg};
                mul_b = ax_reg;
            end
            DP_MUL_SQY:
            begin
                mul_a = {32'b0, ay_reg};
                mul_b = ay_reg;
            end
            DP_MUL_SDX:
            begin
                mul_a = {25'b0, ddx_reg};
                mul_b = {15'b0, fx_term};
            end
            DP_MUL_SDY:
            begin
                mul_a = {25'b0, ddy_reg};
                mul_b = {15'b0, fy_term};
            end
            default: mul_start = 1'b0;
        endcase
    end

    gdcr_div #(
        .NUM_W (48),
        .DEN_W (32)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    gdcr_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == DP_SQRT),
        .rad   (sq_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // shift-add multiplier control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (mul_start)
            begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
            end
            else if (mul_busy_reg)
            begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == 5'd31)
                begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    // shift-add multiplier data
    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            mul_a_reg   <= mul_a;
            mul_b_reg   <= mul_b;
            mul_acc_reg <= '0;
        end
        else if (mul_busy_reg)
        begin
            if (mul_b_reg[0])
                mul_acc_reg <= mul_acc_reg + mul_a_reg;
            mul_a_reg <= mul_a_reg << 1;
            mul_b_reg <= mul_b_reg >> 1;
        end
    end

    // map memory write select
    assign mem_we    = (cmd.op == DP_CLR) || (cmd.op == DP_MEMWR);
    assign mem_waddr = (cmd.op == DP_CLR) ? clr_cnt_reg : {item_reg.cell_y, item_reg.cell_x};
    assign mem_wdata = (cmd.op == DP_CLR) ? 1'b0 : !is_open(item_reg.map_char);

    // map memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            wall_map_reg[mem_waddr] <= mem_wdata;
        rdata_reg <= wall_map_reg[{my_reg[5:0], mx_reg[5:0]}];
    end

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.op == DP_CLR)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // cast registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                item_reg  <= item;
                mx_reg    <= {2'b0, cfg.player_pos_x[21:16]};
                my_reg    <= {2'b0, cfg.player_pos_y[21:16]};
                count_reg <= '0;
                side_reg  <= 1'b0;
            end
            DP_CAP_CAM: cam_reg <= $signed({2'b00, div_quo[28:0]}) - 31'sd65536;
            DP_PROD:
            begin
                px_reg <= cfg.cam_plane_x * cam_reg;
                py_reg <= cfg.cam_plane_y * cam_reg;
            end
            DP_RAY:
            begin
                rx_reg <= rx_c;
                ry_reg <= ry_c;
                ax_reg <= rx_c[32] ? 32'(-rx_c) : rx_c[31:0];
                ay_reg <= ry_c[32] ? 32'(-ry_c) : ry_c[31:0];
            end
            DP_CAP_SQX: sq_reg <= mul_acc_reg;
            DP_CAP_SQY: sq_reg <= sq_reg + mul_acc_reg;
            DP_CAP_LEN: len_reg <= sqrt_root;
            DP_CAP_DDX:
                ddx_reg <= (ax_reg == 32'd0 || div_quo > 48'(DELTA_CAP)) ? DELTA_CAP
                                                                        : div_quo[38:0];
            DP_CAP_DDY:
                ddy_reg <= (ay_reg == 32'd0 || div_quo > 48'(DELTA_CAP)) ? DELTA_CAP
                                                                        : div_quo[38:0];
            DP_CAP_SDX: sdx_reg <= mul_acc_reg[63:16];
            DP_CAP_SDY: sdy_reg <= mul_acc_reg[63:16];
            DP_STEP:
            begin
                count_reg <= count_reg + 1'b1;
                if (sdx_reg < sdy_reg)
                begin
                    sdx_reg  <= sdx_reg + {9'b0, ddx_reg};
                    mx_reg   <= rx_pos ? mx_reg - 8'sd1 : mx_reg + 8'sd1;
                    side_reg <= 1'b0;
                end
                else
                begin
                    sdy_reg  <= sdy_reg + {9'b0, ddy_reg};
                    my_reg   <= ry_pos ? my_reg - 8'sd1 : my_reg + 8'sd1;
                    side_reg <= 1'b1;
                end
            end
            DP_HIT:
            begin
                an_reg  <= num_c[24] ? 24'(-num_c) : num_c[23:0];
                den_reg <= side_reg ? ay_reg : ax_reg;
            end
            DP_CAP_ROW:
                rh_reg <= $signed({2'b00, div_quo}) - $signed({27'b0, hq, 16'b0});
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOST:
            begin
                res_reg.hit_side      <= 1'b0;
                res_reg.wall_face     <= 2'd0;
                res_reg.hit_cell_x    <= 6'd0;
                res_reg.hit_cell_y    <= 6'd0;
                res_reg.perp_distance <= PERP_MAX;
                res_reg.left_map      <= 1'b1;
            end
            DP_HIT:
            begin
                res_reg.hit_side      <= side_reg;
                res_reg.wall_face     <= side_reg ? (ry_pos ? 2'd3 : 2'd2)
                                                  : (rx_pos ? 2'd1 : 2'd0);
                res_reg.hit_cell_x    <= mx_reg[5:0];
                res_reg.hit_cell_y    <= my_reg[5:0];
                res_reg.perp_distance <= PERP_MAX;
                res_reg.left_map      <= 1'b0;
            end
            DP_CAP_DIST:
                res_reg.perp_distance <= (div_quo > 48'(PERP_MAX)) ? PERP_MAX : div_quo[23:0];
            DP_FIN:
            begin
                res_reg.wall_top_row <= t2[50] ? 12'd0 : t2[28:17];
                if (b2[50])
                    res_reg.wall_bottom_row <= 12'd0;
                else if (bs >= {21'b0, h_eff})
                    res_reg.wall_bottom_row <= h_eff - 12'd1;
                else
                    res_reg.wall_bottom_row <= bs[11:0];
            end
            default: ;
        endcase
    end

    // status to the controller
    assign status.clr_last   = clr_cnt_reg == MAP_AW'(MAP_CELLS - 1);
    assign status.div_done   = div_done;
    assign status.mul_done   = mul_done_reg;
    assign status.sqrt_done  = sqrt_done;
    assign status.out_of_map = mx_reg < 8'sd0 || my_reg < 8'sd0
                             || mx_reg >= 8'(MAP_SIDE) || my_reg >= 8'(MAP_SIDE);
    assign status.wall       = rdata_reg;
    assign status.steps_done = count_reg == CNT_W'(MAX_STEPS);
    assign status.den_zero   = den_reg == 32'd0;

    assign result = res_reg;

endmodule

[src/gdcr_ctrl.sv]
// raycaster sequencer: map clear, write, ray setup, walk and projection
module gdcr_ctrl
    import gdcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       operation,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_WRITE  = 5'd2;
    localparam logic [4:0] S_CAM    = 5'd3;
    localparam logic [4:0] S_CAM_W  = 5'd4;
    localparam logic [4:0] S_PROD   = 5'd5;
    localparam logic [4:0] S_RAY    = 5'd6;
    localparam logic [4:0] S_SQX    = 5'd7;
    localparam logic [4:0] S_SQX_W  = 5'd8;
    localparam logic [4:0] S_SQY    = 5'd9;
    localparam logic [4:0] S_SQY_W  = 5'd10;
    localparam logic [4:0] S_SQRT   = 5'd11;
    localparam logic [4:0] S_SQRT_W = 5'd12;
    localparam logic [4:0] S_DDX    = 5'd13;
    localparam logic [4:0] S_DDX_W  = 5'd14;
    localparam logic [4:0] S_DDY    = 5'd15;
    localparam logic [4:0] S_DDY_W  = 5'd16;
    localparam logic [4:0] S_SDX    = 5'd17;
    localparam logic [4:0] S_SDX_W  = 5'd18;
    localparam logic [4:0] S_SDY    = 5'd19;
    localparam logic [4:0] S_SDY_W  = 5'd20;
    localparam logic [4:0] S_STEP   = 5'd21;
    localparam logic [4:0] S_READ   = 5'd22;
    localparam logic [4:0] S_CHECK  = 5'd23;
    localparam logic [4:0] S_DIST   = 5'd24;
    localparam logic [4:0] S_DIST_W = 5'd25;
    localparam logic [4:0] S_ROW    = 5'd26;
    localparam logic [4:0] S_ROW_W  = 5'd27;
    localparam logic [4:0] S_FIN    = 5'd28;
    localparam logic [4:0] S_OUT    = 5'd29;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = DP_CLR;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = (operation == OP_WRITE) ? S_WRITE : S_CAM;
                end
            end
            S_WRITE:
            begin
                cmd.op     = DP_MEMWR;
                state_next = S_IDLE;
            end
            S_CAM:
            begin
                cmd.op     = DP_DIV_CAM;
                state_next = S_CAM_W;
            end
            S_CAM_W:
            begin
                if (status.div_done)
                begin
                    cmd.op     = DP_CAP_CAM;
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.op     = DP_PROD;
                state_next = S_RAY;
            end
            S_RAY:
            begin
                cmd.op     = DP_RAY;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                cmd.op     = DP_MUL_SQX;
                state_next = S_SQX_W;
            end
            S_SQX_W:
            begin
                if (status.mul_done)
                begin
                    cmd.op     = DP_CAP_SQX;
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                cmd.op     = DP_MUL_SQY;
                state_next = S_SQY_W;
            end
            S_SQY_W:
            begin
                if (status.mul_done)
                begin
                    cmd.op     = DP_CAP_SQY;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op     = DP_SQRT;
                state_next = S_SQRT_W;
            end
            S_SQRT_W:
            begin
                if (status.sqrt_done)
                begin
                    cmd.op     = DP_CAP_LEN;
                    state_next = S_DDX;
                end
            end
            S_DDX:
            begin
                cmd.op     = DP_DIV_DDX;
                state_next = S_DDX_W;
            end
            S_DDX_W:
            begin
                if (status.div_done)
                begin
                    cmd.op     = DP_CAP_DDX;
                    state_next = S_DDY;
                end
            end
            S_DDY:
            begin
                cmd.op     = DP_DIV_DDY;
                state_next = S_DDY_W;
            end
            S_DDY_W:
            begin
                if (status.div_done)
                begin
                    cmd.op     = DP_CAP_DDY;
                    state_next = S_SDX;
                end
            end
            S_SDX:
            begin
                cmd.op     = DP_MUL_SDX;
                state_next = S_SDX_W;
            end
            S_SDX_W:
            begin
                if (status.mul_done)
                begin
                    cmd.op     = DP_CAP_SDX;
                    state_next = S_SDY;
                end
            end
            S_SDY:
            begin
                cmd.op     = DP_MUL_SDY;
                state_next = S_SDY_W;
            end
            S_SDY_W:
            begin
                if (status.mul_done)
                begin
                    cmd.op     = DP_CAP_SDY;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.op     = DP_STEP;
                state_next = S_READ;
            end
            S_READ:
            begin
                if (status.out_of_map)
                begin
                    cmd.op     = DP_LOST;
                    state_next = S_ROW;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.wall)
                begin
                    cmd.op     = DP_HIT;
                    state_next = S_DIST;
                end
                else if (status.steps_done)
                begin
                    cmd.op     = DP_LOST;
                    state_next = S_ROW;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_DIST:
            begin
                if (status.den_zero)
                begin
                    state_next = S_ROW;
                end
                else
                begin
                    cmd.op     = DP_DIV_DIST;
                    state_next = S_DIST_W;
                end
            end
            S_DIST_W:
            begin
                if (status.div_done)
                begin
                    cmd.op     = DP_CAP_DIST;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.op     = DP_DIV_ROW;
                state_next = S_ROW_W;
            end
            S_ROW_W:
            begin
                if (status.div_done)
                begin
                    cmd.op     = DP_CAP_ROW;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.op     = DP_FIN;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_OUT;

endmodule

[src/grid_dda_column_raycaster_core.sv]
// top level of the grid dda column raycaster
//
// Takes one transaction at a time while busy is low. A cast walks at most MAX_STEPS
// grid steps and uses up to five divisions through one shared 48-step radix-2
// divider, four products through a 32-step shift-add multiplier and a 32-step square
// root; each step of the walk passes through the step, read and check states for the
// map memory read. A lost ray or a zero denominator skips the distance division. Its
// result is marked by done, high for a single cycle; the receiver cannot stall and
// must take it then. After reset the block clears its 4096-cell map, one cell per
// cycle, and holds busy high while it does so; configuration writes are taken
// throughout.
`include "grid_dda_column_raycaster_core_assert.svh"

module grid_dda_column_raycaster_core
    import gdcr_pkg::*;
#(
    parameter int MAX_STEPS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        done,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_we;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= 12'd640;
            cfg_reg.screen_height <= 12'd480;
            cfg_reg.player_pos_x  <= 22'd2129920;
            cfg_reg.player_pos_y  <= 22'd2129920;
            cfg_reg.view_dir_x    <= 18'sd65536;
            cfg_reg.view_dir_y    <= 18'sd0;
            cfg_reg.cam_plane_x   <= 18'sd0;
            cfg_reg.cam_plane_y   <= 18'sd43254;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SCREEN_W: cfg_reg.screen_width  <= pwdata[11:0];
                REG_SCREEN_H: cfg_reg.screen_height <= pwdata[11:0];
                REG_POS_X:    cfg_reg.player_pos_x  <= pwdata[21:0];
                REG_POS_Y:    cfg_reg.player_pos_y  <= pwdata[21:0];
                REG_DIR_X:    cfg_reg.view_dir_x    <= $signed(pwdata[17:0]);
                REG_DIR_Y:    cfg_reg.view_dir_y    <= $signed(pwdata[17:0]);
                REG_PLANE_X:  cfg_reg.cam_plane_x   <= $signed(pwdata[17:0]);
                REG_PLANE_Y:  cfg_reg.cam_plane_y   <= $signed(pwdata[17:0]);
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_SCREEN_W: prdata = {20'b0, cfg_reg.screen_width};
            REG_SCREEN_H: prdata = {20'b0, cfg_reg.screen_height};
            REG_POS_X:    prdata = {10'b0, cfg_reg.player_pos_x};
            REG_POS_Y:    prdata = {10'b0, cfg_reg.player_pos_y};
            REG_DIR_X:    prdata = {14'b0, cfg_reg.view_dir_x};
            REG_DIR_Y:    prdata = {14'b0, cfg_reg.view_dir_y};
            REG_PLANE_X:  prdata = {14'b0, cfg_reg.cam_plane_x};
            REG_PLANE_Y:  prdata = {14'b0, cfg_reg.cam_plane_y};
            default:      prdata = 32'd0;
        endcase
    end

    gdcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    gdcr_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .cfg    (cfg_reg),
        .status (status),
        .result (result)
    );

    // checks
    `GDCR_ASSERT_SAME(a_done_busy, done, busy, "result strobe outside a cast")
    `GDCR_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `GDCR_ASSERT_NEXT(a_write_silent, start && !busy && item.operation == OP_WRITE, !done,
        "map write produced a result")
    `GDCR_ASSERT_SAME(a_lost_fields, done && result.left_map,
        result.perp_distance == PERP_MAX && result.hit_cell_x == 6'd0
        && result.hit_cell_y == 6'd0, "lost ray with hit fields set")

endmodule
